// ----- rtl/pit_pkg.sv -----
// Shared constants for the point-in-tetrahedron test.
// No dependencies; imported by pit_det3 and point_in_tetrahedron_test.
package pit_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int LANE_W         = 16;
  localparam int VERT_W         = 3 * LANE_W;
  localparam int NUM_VERT       = 4;
  localparam int NUM_DET        = NUM_VERT + 1;
  localparam int VOL_BITS       = 52;
  localparam int CFG_IDX_W      = 2;
  localparam int PIPE_DEPTH     = 4;

  localparam logic [CFG_IDX_W-1:0] IDX_VERTEX_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] IDX_VERTEX_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] IDX_VERTEX_C = 2'd2;
  localparam logic [CFG_IDX_W-1:0] IDX_VERTEX_D = 2'd3;

endpackage

// ----- rtl/pit_det3.sv -----
// Four-stage pipelined determinant det[r0-r1; r0-r2; r0-r3] of 3-D integer rows.
// Depends on pit_pkg; advances all stages together on en.
module pit_det3
  import pit_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int DIFF_W = COORD_BITS + 1,
  localparam int PROD_W = 2 * DIFF_W,
  localparam int MIN_W  = PROD_W + 1,
  localparam int TERM_W = DIFF_W + MIN_W,
  localparam int DET_W  = TERM_W + 2
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [2:0][COORD_BITS-1:0]   row0,
  input  logic [2:0][COORD_BITS-1:0]   row1,
  input  logic [2:0][COORD_BITS-1:0]   row2,
  input  logic [2:0][COORD_BITS-1:0]   row3,
  output logic signed [DET_W-1:0]      det
);

  logic signed [DIFF_W-1:0] a_nxt [3];
  logic signed [DIFF_W-1:0] b_nxt [3];
  logic signed [DIFF_W-1:0] c_nxt [3];
  logic signed [DIFF_W-1:0] a_r   [3];
  logic signed [DIFF_W-1:0] b_r   [3];
  logic signed [DIFF_W-1:0] c_r   [3];

  logic signed [DIFF_W-1:0] a2_r  [3];
  logic signed [PROD_W-1:0] b1c2_r, b2c1_r, b0c2_r, b2c0_r, b0c1_r, b1c0_r;

  logic signed [MIN_W-1:0]  min_nxt  [3];
  logic signed [TERM_W-1:0] term_nxt [3];
  logic signed [TERM_W-1:0] term_r   [3];

  logic signed [DET_W-1:0]  det_nxt;
  logic signed [DET_W-1:0]  det_r;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      a_nxt[j] = DIFF_W'($signed(row0[j])) - DIFF_W'($signed(row1[j]));
      b_nxt[j] = DIFF_W'($signed(row0[j])) - DIFF_W'($signed(row2[j]));
      c_nxt[j] = DIFF_W'($signed(row0[j])) - DIFF_W'($signed(row3[j]));
    end
  end

  always_comb begin
    min_nxt[0] = MIN_W'(b1c2_r) - MIN_W'(b2c1_r);
    min_nxt[1] = MIN_W'(b0c2_r) - MIN_W'(b2c0_r);
    min_nxt[2] = MIN_W'(b0c1_r) - MIN_W'(b1c0_r);
    for (int j = 0; j < 3; j++) begin
      term_nxt[j] = TERM_W'(a2_r[j]) * TERM_W'(min_nxt[j]);
    end
    det_nxt = DET_W'(term_r[0]) - DET_W'(term_r[1]) + DET_W'(term_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        a_r[j]    <= a_nxt[j];
        b_r[j]    <= b_nxt[j];
        c_r[j]    <= c_nxt[j];
        a2_r[j]   <= a_r[j];
        term_r[j] <= term_nxt[j];
      end
      b1c2_r <= PROD_W'(b_r[1]) * PROD_W'(c_r[2]);
      b2c1_r <= PROD_W'(b_r[2]) * PROD_W'(c_r[1]);
      b0c2_r <= PROD_W'(b_r[0]) * PROD_W'(c_r[2]);
      b2c0_r <= PROD_W'(b_r[2]) * PROD_W'(c_r[0]);
      b0c1_r <= PROD_W'(b_r[0]) * PROD_W'(c_r[1]);
      b1c0_r <= PROD_W'(b_r[1]) * PROD_W'(c_r[0]);
      det_r  <= det_nxt;
    end
  end

  assign det = det_r;

endmodule

// ----- rtl/point_in_tetrahedron_test.sv -----
// Top level of the point-in-tetrahedron test: vertex registers, five
// determinant pipelines and the result register. Depends on pit_pkg, pit_det3.
//
// Usage:
//   Write the four vertices through cfg_we / cfg_index / cfg_wdata, packed
//   z[47:32] y[31:16] x[15:0], while no beat is in flight. Then stream query
//   points on the in_ channel (valid/ready); each point yields one out_ beat
//   carrying inside_res, volume_six, flat_on_axis and singular.
//   From input acceptance to out_valid a point passes four stages of
//   the determinant pipelines (differences, products, minor times row,
//   three-term sum) and one result register that forms the sign tests.
//   Throughput is one point per cycle unless out_ready stalls; all five
//   determinants of a point are computed side by side on separate units.
//   Reset clears the vertices to zero and empties the pipeline.
//   When the receiver holds out_ready low with a beat waiting, the whole
//   pipeline holds and in_ready drops; nothing is lost or repeated, and
//   in_ready returns in the same cycle out_ready does.
module point_in_tetrahedron_test
  import pit_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [VERT_W-1:0]           cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [LANE_W-1:0]    in_point_x,
  input  logic signed [LANE_W-1:0]    in_point_y,
  input  logic signed [LANE_W-1:0]    in_point_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_inside_res,
  output logic signed [VOL_BITS-1:0]  out_volume_six,
  output logic                        out_flat_on_axis,
  output logic                        out_singular
);

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int MIN_W  = 2 * DIFF_W + 1;
  localparam int DET_W  = DIFF_W + MIN_W + 2;
  localparam int EXT_W  = (DET_W > VOL_BITS) ? DET_W : VOL_BITS;

  typedef logic [2:0][COORD_BITS-1:0] coord3_t;

  logic [VERT_W-1:0]        vert_r   [NUM_VERT];
  logic [VERT_W-1:0]        vert_nxt [NUM_VERT];
  coord3_t                  vert_c   [NUM_VERT];
  coord3_t                  pnt_c;
  logic                     adv;
  logic [PIPE_DEPTH-1:0]    vld_r;
  logic signed [DET_W-1:0]  det_w [NUM_DET];

  logic                     out_valid_r;
  logic                     inside_r;
  logic signed [VOL_BITS-1:0] volume_r;
  logic                     flat_r;
  logic                     singular_r;

  logic                     sing_nxt;
  logic                     pos_nxt;
  logic                     inside_nxt;
  logic                     flat_nxt;
  logic signed [EXT_W-1:0]  vol_ext;

  // Configuration writes
  always_comb begin
    for (int v = 0; v < NUM_VERT; v++) begin
      vert_nxt[v] = vert_r[v];
    end
    if (cfg_we) begin
      case (cfg_index)
        IDX_VERTEX_A: vert_nxt[0] = cfg_wdata;
        IDX_VERTEX_B: vert_nxt[1] = cfg_wdata;
        IDX_VERTEX_C: vert_nxt[2] = cfg_wdata;
        IDX_VERTEX_D: vert_nxt[3] = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < NUM_VERT; v++) begin
        vert_r[v] <= '0;
      end
    end else begin
      for (int v = 0; v < NUM_VERT; v++) begin
        vert_r[v] <= vert_nxt[v];
      end
    end
  end

  // Unpack coordinates to the active width
  always_comb begin
    for (int v = 0; v < NUM_VERT; v++) begin
      for (int j = 0; j < 3; j++) begin
        vert_c[v][j] = vert_r[v][j*LANE_W +: COORD_BITS];
      end
    end
    pnt_c[0] = in_point_x[COORD_BITS-1:0];
    pnt_c[1] = in_point_y[COORD_BITS-1:0];
    pnt_c[2] = in_point_z[COORD_BITS-1:0];
  end

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Determinant zero uses the vertices; determinant k swaps in the point
  for (genvar k = 0; k < NUM_DET; k++) begin : g_det
    pit_det3 #(
      .COORD_BITS (COORD_BITS)
    ) u_det (
      .clk  (clk),
      .en   (adv),
      .row0 ((k == 1) ? pnt_c : vert_c[0]),
      .row1 ((k == 2) ? pnt_c : vert_c[1]),
      .row2 ((k == 3) ? pnt_c : vert_c[2]),
      .row3 ((k == 4) ? pnt_c : vert_c[3]),
      .det  (det_w[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_valid};
    end
  end

  always_comb begin
    sing_nxt   = (det_w[0] == '0);
    pos_nxt    = (det_w[0] > 0);
    inside_nxt = !sing_nxt;
    for (int k = 1; k < NUM_DET; k++) begin
      if ((det_w[k] > 0) != pos_nxt) begin
        inside_nxt = 1'b0;
      end
    end
    flat_nxt = 1'b0;
    for (int j = 0; j < 3; j++) begin
      if (vert_c[0][j] == vert_c[1][j] && vert_c[0][j] == vert_c[2][j] &&
          vert_c[0][j] == vert_c[3][j]) begin
        flat_nxt = 1'b1;
      end
    end
    vol_ext = EXT_W'(det_w[0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      inside_r   <= inside_nxt;
      volume_r   <= vol_ext[VOL_BITS-1:0];
      flat_r     <= flat_nxt;
      singular_r <= sing_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_inside_res   = inside_r;
  assign out_volume_six   = volume_r;
  assign out_flat_on_axis = flat_r;
  assign out_singular     = singular_r;

endmodule

// ----- tb/point_in_tetrahedron_test_tb.sv -----
// Self-checking testbench for point_in_tetrahedron_test: directed and random query points
// against several vertex sets, checked beat by beat against an in-bench integer predictor.
// Depends on pit_pkg and the point_in_tetrahedron_test RTL.
module point_in_tetrahedron_test_tb;
  import pit_pkg::*;

  localparam int COORD_W = COORD_BITS_DEF;
  localparam int CLK_HALF = 4;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    longint x;
    longint y;
    longint z;
  } coord3_t;

  typedef struct packed {
    logic                hit;
    logic [VOL_BITS-1:0] volume;
    logic                flat;
    logic                singular;
  } verdict_t;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = IDX_VERTEX_A;
  logic [VERT_W-1:0]          cfg_wdata = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [LANE_W-1:0]   in_point_x = '0;
  logic signed [LANE_W-1:0]   in_point_y = '0;
  logic signed [LANE_W-1:0]   in_point_z = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       out_inside_res;
  logic signed [VOL_BITS-1:0] out_volume_six;
  logic                       out_flat_on_axis;
  logic                       out_singular;

  logic [VERT_W-1:0] vert_word [NUM_VERT];
  verdict_t          pending_verdicts [$];
  int                mismatches = 0;
  bit                calm = 1'b0;

  point_in_tetrahedron_test #(
    .COORD_BITS(COORD_W)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_point_x       (in_point_x),
    .in_point_y       (in_point_y),
    .in_point_z       (in_point_z),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_inside_res   (out_inside_res),
    .out_volume_six   (out_volume_six),
    .out_flat_on_axis (out_flat_on_axis),
    .out_singular     (out_singular)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    #(2 * CLK_HALF * LIMIT_CYCLES);
    $display("[point_in_tetrahedron_test] ERROR");
    $finish;
  end

  function automatic longint lane_value(input logic [LANE_W-1:0] raw);
    logic [LANE_W-1:0] shifted;
    shifted = raw << (LANE_W - COORD_W);
    return longint'($signed(shifted)) >>> (LANE_W - COORD_W);
  endfunction

  function automatic coord3_t unpack_vertex(input logic [VERT_W-1:0] word);
    coord3_t c;
    c.x = lane_value(word[15:0]);
    c.y = lane_value(word[31:16]);
    c.z = lane_value(word[47:32]);
    return c;
  endfunction

  function automatic longint det_rows(input coord3_t r0, input coord3_t r1,
                                     input coord3_t r2, input coord3_t r3);
    longint ax, ay, az, bx, by, bz, cx, cy, cz;
    ax = r0.x - r1.x; ay = r0.y - r1.y; az = r0.z - r1.z;
    bx = r0.x - r2.x; by = r0.y - r2.y; bz = r0.z - r2.z;
    cx = r0.x - r3.x; cy = r0.y - r3.y; cz = r0.z - r3.z;
    return ax * (by * cz - bz * cy) - ay * (bx * cz - bz * cx) + az * (bx * cy - by * cx);
  endfunction

  function automatic verdict_t classify_point(input logic [LANE_W-1:0] px,
                                              input logic [LANE_W-1:0] py,
                                              input logic [LANE_W-1:0] pz);
    coord3_t  v [NUM_VERT];
    coord3_t  r [NUM_VERT];
    coord3_t  p;
    longint   d0;
    longint   dk;
    bit       positive;
    verdict_t res;
    for (int i = 0; i < NUM_VERT; i++) v[i] = unpack_vertex(vert_word[i]);
    p.x = lane_value(px);
    p.y = lane_value(py);
    p.z = lane_value(pz);
    d0 = det_rows(v[0], v[1], v[2], v[3]);
    positive = d0 > 0;
    res.singular = d0 == 0;
    res.volume = d0[VOL_BITS-1:0];
    res.hit = !res.singular;
    for (int k = 0; k < NUM_VERT; k++) begin
      for (int j = 0; j < NUM_VERT; j++) r[j] = (j == k) ? p : v[j];
      dk = det_rows(r[0], r[1], r[2], r[3]);
      if ((dk > 0) != positive) res.hit = 1'b0;
    end
    res.flat = (v[0].x == v[1].x && v[0].x == v[2].x && v[0].x == v[3].x) ||
               (v[0].y == v[1].y && v[0].y == v[2].y && v[0].y == v[3].y) ||
               (v[0].z == v[1].z && v[0].z == v[2].z && v[0].z == v[3].z);
    return res;
  endfunction

  function automatic logic [VERT_W-1:0] pack_vertex(input longint x, input longint y,
                                                    input longint z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  function automatic longint clamp_lane(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 12);
  end

  always @(posedge clk) begin : check_results
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected beat: inside=%0b volume=%0d flat=%0b singular=%0b",
                   out_inside_res, out_volume_six, out_flat_on_axis, out_singular);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        if (want.hit !== out_inside_res || want.volume !== out_volume_six ||
            want.flat !== out_flat_on_axis || want.singular !== out_singular) begin
          if (mismatches < 10)
            $display({"mismatch: exp inside=%0b volume=%0d flat=%0b singular=%0b,",
                      " got inside=%0b volume=%0d flat=%0b singular=%0b"},
                     want.hit, $signed(want.volume), want.flat, want.singular,
                     out_inside_res, out_volume_six, out_flat_on_axis, out_singular);
          mismatches++;
        end
      end
    end
  end

  task automatic send_point(input longint x, input longint y, input longint z);
    if (!calm && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_point_x <= 16'(x);
    in_point_y <= 16'(y);
    in_point_z <= 16'(z);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_verdicts.push_back(classify_point(16'(x), 16'(y), 16'(z)));
  endtask

  task automatic drain_results;
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic write_vertex(input logic [CFG_IDX_W-1:0] idx, input logic [VERT_W-1:0] word);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= word;
    vert_word[idx] = word;
    @(posedge clk);
  endtask

  task automatic set_tetra(input logic [VERT_W-1:0] a, input logic [VERT_W-1:0] b,
                           input logic [VERT_W-1:0] c, input logic [VERT_W-1:0] d);
    write_vertex(IDX_VERTEX_A, a);
    write_vertex(IDX_VERTEX_B, b);
    write_vertex(IDX_VERTEX_C, c);
    write_vertex(IDX_VERTEX_D, d);
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_state;
    send_point(0, 0, 0);
    send_point(-32768, 32767, 5);
    drain_results();
  endtask

  task automatic test_unit_tetra;
    set_tetra(pack_vertex(0, 0, 0), pack_vertex(100, 0, 0),
              pack_vertex(0, 100, 0), pack_vertex(0, 0, 100));
    send_point(10, 10, 10);
    send_point(0, 0, 0);
    send_point(50, 50, 0);
    send_point(200, 200, 200);
    send_point(-32768, -32768, -32768);
    send_point(32767, 32767, 32767);
    drain_results();
    // mirrored orientation flips the sign of the vertex determinant
    set_tetra(pack_vertex(0, 0, 0), pack_vertex(0, 100, 0),
              pack_vertex(100, 0, 0), pack_vertex(0, 0, 100));
    send_point(10, 10, 10);
    send_point(0, 0, 0);
    send_point(25, 25, 0);
    drain_results();
  endtask

  task automatic test_extreme_coords;
    calm = 1'b1;
    set_tetra(pack_vertex(-32768, -32768, -32768), pack_vertex(32767, -32768, -32768),
              pack_vertex(-32768, 32767, -32768), pack_vertex(-32768, -32768, 32767));
    send_point(0, 0, 0);
    send_point(-32768, -32768, -32768);
    send_point(32767, 32767, 32767);
    send_point(-32767, -32767, 32767);
    drain_results();
    calm = 1'b0;
  endtask

  task automatic test_flat_and_singular;
    set_tetra(pack_vertex(7, 0, 0), pack_vertex(7, 5, 0),
              pack_vertex(7, 0, 5), pack_vertex(7, 3, 3));
    send_point(7, 1, 1);
    drain_results();
    set_tetra(pack_vertex(0, -9, 0), pack_vertex(5, -9, 0),
              pack_vertex(0, -9, 5), pack_vertex(3, -9, 3));
    send_point(1, -9, 1);
    drain_results();
    set_tetra(pack_vertex(0, 0, 32767), pack_vertex(5, 0, 32767),
              pack_vertex(0, 5, 32767), pack_vertex(3, 3, 32767));
    send_point(1, 1, 32767);
    drain_results();
    set_tetra(pack_vertex(1, -1, 0), pack_vertex(0, 1, -1),
              pack_vertex(-1, 0, 1), pack_vertex(2, -1, -1));
    send_point(0, 0, 0);
    drain_results();
  endtask

  task automatic test_random_tetrahedra;
    longint vc [NUM_VERT][3];
    longint lo [3];
    longint hi [3];
    longint ctr [3];
    longint pt [3];
    longint wt [NUM_VERT];
    longint wsum;
    longint span;
    logic [31:0] raw;
    int mode;
    int pick;
    int axis;
    for (int phase = 0; phase < 12; phase++) begin
      calm = (phase == 5);
      case (phase)
        2, 8:    mode = 1;
        6:       mode = 2;
        11:      mode = 3;
        default: mode = 0;
      endcase
      for (int a = 0; a < 3; a++) ctr[a] = longint'($urandom_range(0, 40000)) - 20000;
      span = $urandom_range(2, 1500);
      for (int i = 0; i < NUM_VERT; i++) begin
        for (int a = 0; a < 3; a++) begin
          raw = $urandom;
          case (mode)
            1:       vc[i][a] = lane_value(raw[15:0]);
            3:       vc[i][a] = raw[0] ? 32767 : -32768;
            default: vc[i][a] = ctr[a] + longint'($urandom_range(0, 2 * span)) - span;
          endcase
        end
      end
      if (mode == 2) begin
        if ($urandom_range(0, 1) == 1) begin
          for (int a = 0; a < 3; a++) vc[3][a] = vc[1][a];
        end else begin
          axis = $urandom_range(0, 2);
          for (int i = 1; i < NUM_VERT; i++) vc[i][axis] = vc[0][axis];
        end
      end
      for (int a = 0; a < 3; a++) begin
        lo[a] = vc[0][a];
        hi[a] = vc[0][a];
        for (int i = 1; i < NUM_VERT; i++) begin
          if (vc[i][a] < lo[a]) lo[a] = vc[i][a];
          if (vc[i][a] > hi[a]) hi[a] = vc[i][a];
        end
      end
      set_tetra(pack_vertex(vc[0][0], vc[0][1], vc[0][2]),
                pack_vertex(vc[1][0], vc[1][1], vc[1][2]),
                pack_vertex(vc[2][0], vc[2][1], vc[2][2]),
                pack_vertex(vc[3][0], vc[3][1], vc[3][2]));
      for (int n = 0; n < 155; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          wsum = 0;
          for (int i = 0; i < NUM_VERT; i++) begin
            wt[i] = $urandom_range(0, 15);
            wsum += wt[i];
          end
          if (wsum == 0) begin
            wt[0] = 1;
            wsum = 1;
          end
          for (int a = 0; a < 3; a++) begin
            pt[a] = 0;
            for (int i = 0; i < NUM_VERT; i++) pt[a] += wt[i] * vc[i][a];
            pt[a] = clamp_lane(pt[a] / wsum + longint'($urandom_range(0, 6)) - 3);
          end
        end else if (pick < 90) begin
          for (int a = 0; a < 3; a++)
            pt[a] = lo[a] + longint'($urandom_range(0, 32'(hi[a] - lo[a])));
        end else begin
          for (int a = 0; a < 3; a++) begin
            raw = $urandom;
            pt[a] = lane_value(raw[15:0]);
          end
        end
        send_point(pt[0], pt[1], pt[2]);
      end
      drain_results();
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_unit_tetra();
    test_extreme_coords();
    test_flat_and_singular();
    test_random_tetrahedra();
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("[point_in_tetrahedron_test] OK");
    end else begin
      $display("[point_in_tetrahedron_test] ERROR");
    end
    $finish;
  end

endmodule
